@@ rtl/tkres_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-key record exchange sort package
// Shared widths, record type, controller command and status groups, and the
// record ordering function.
// ----------------------------------------------------------------------------
package tkres_pkg;

  localparam int MaxRecords = 64;
  localparam int IdxW       = $clog2(MaxRecords);
  localparam int CntW       = $clog2(MaxRecords + 1);

  localparam int DevW  = 14;
  localparam int HrsW  = 5;
  localparam int MinW  = 6;
  localparam int SecW  = 6;
  localparam int TagW  = 6;
  localparam int KeyW  = 19;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgDeviceAscending = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTimeLaterFirst  = 1'd1;

  localparam logic [KeyW-1:0] HourScale   = KeyW'(10000);
  localparam logic [KeyW-1:0] MinuteScale = KeyW'(100);

  typedef struct packed {
    logic [DevW-1:0] device;
    logic [HrsW-1:0] hrs;
    logic [MinW-1:0] mins;
    logic [SecW-1:0] secs;
    logic [TagW-1:0] tag;
  } rec_t;

  typedef struct packed {
    logic in_ready;
    logic rd_i;
    logic rd_j;
    logic rd_k;
    logic cap_a;
    logic cmp;
    logic wr_i;
    logic out_valid;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic in_acc;
    logic in_last;
    logic n_small;
    logic i_end;
    logic j_end;
    logic k_end;
    logic out_acc;
  } status_t;

  function automatic logic [KeyW-1:0] time_key(input rec_t r);
    return KeyW'(r.hrs) * HourScale + KeyW'(r.mins) * MinuteScale + KeyW'(r.secs);
  endfunction

  // True when record b must move ahead of record a.
  function automatic logic should_swap(input rec_t a, input rec_t b,
                                       input logic dev_asc, input logic later_first);
    logic [KeyW-1:0] ka;
    logic [KeyW-1:0] kb;
    logic            res;
    ka = time_key(a);
    kb = time_key(b);
    if (a.device != b.device) begin
      res = dev_asc ? (a.device > b.device) : (a.device < b.device);
    end else begin
      res = later_first ? (ka < kb) : (ka > kb);
    end
    return res;
  endfunction

endpackage

@@ rtl/tkres_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-key record exchange sort channel interfaces
// Input record channel, sorted result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface tkres_rec_if;
  logic                        valid;
  logic                        ready;
  logic [tkres_pkg::DevW-1:0]  device_number;
  logic [tkres_pkg::HrsW-1:0]  hours;
  logic [tkres_pkg::MinW-1:0]  minutes;
  logic [tkres_pkg::SecW-1:0]  seconds;
  logic                        last_record;

  modport source (output valid, device_number, hours, minutes, seconds, last_record,
                  input ready);
  modport sink   (input valid, device_number, hours, minutes, seconds, last_record,
                  output ready);
endinterface

interface tkres_res_if;
  logic                        valid;
  logic                        ready;
  logic [tkres_pkg::DevW-1:0]  out_device;
  logic [tkres_pkg::HrsW-1:0]  out_hours;
  logic [tkres_pkg::MinW-1:0]  out_minutes;
  logic [tkres_pkg::SecW-1:0]  out_seconds;
  logic [tkres_pkg::TagW-1:0]  arrival_tag;
  logic                        last_out;

  modport source (output valid, out_device, out_hours, out_minutes, out_seconds,
                  arrival_tag, last_out, input ready);
  modport sink   (input valid, out_device, out_hours, out_minutes, out_seconds,
                  arrival_tag, last_out, output ready);
endinterface

interface tkres_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tkres_pkg::CfgIdxW-1:0]  index;
  logic [tkres_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/tkres_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-key record exchange sort datapath
// Record store, sort counters, held record, comparator and config registers.
// ----------------------------------------------------------------------------
module tkres_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  tkres_rec_if.sink           rec_i,
  tkres_res_if.source         res_o,
  tkres_cfg_if.sink           cfg_i,
  input  tkres_pkg::cmd_t     cmd_i,
  output tkres_pkg::status_t  status_o
);

  tkres_pkg::rec_t mem [tkres_pkg::MaxRecords];
  tkres_pkg::rec_t rdata_q;
  tkres_pkg::rec_t a_q;
  tkres_pkg::rec_t new_rec;
  tkres_pkg::rec_t wr_data;

  logic [tkres_pkg::CntW-1:0] count_q, count_d;
  logic [tkres_pkg::IdxW-1:0] i_q, i_d;
  logic [tkres_pkg::IdxW-1:0] j_q, j_d;
  logic [tkres_pkg::IdxW-1:0] k_q, k_d;
  logic [tkres_pkg::IdxW-1:0] wr_addr;
  logic [tkres_pkg::IdxW-1:0] rd_addr;
  logic                       dev_asc_q, dev_asc_d;
  logic                       later_first_q, later_first_d;
  logic                       load_en, store_en, swap, wr_en, rd_en, out_acc, k_end;

  assign load_en  = cmd_i.in_ready & rec_i.valid;
  assign store_en = load_en & (count_q < tkres_pkg::CntW'(tkres_pkg::MaxRecords));
  assign swap     = tkres_pkg::should_swap(a_q, rdata_q, dev_asc_q, later_first_q);
  assign out_acc  = res_o.valid & res_o.ready;
  assign k_end    = (tkres_pkg::CntW'(k_q) + tkres_pkg::CntW'(1)) == count_q;

  always_comb begin
    new_rec.device = rec_i.device_number;
    new_rec.hrs    = rec_i.hours;
    new_rec.mins   = rec_i.minutes;
    new_rec.secs   = rec_i.seconds;
    new_rec.tag    = tkres_pkg::TagW'(count_q);
  end

  // Single write port: loading, swap write-back at j, or final write at i.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = a_q;
    if (store_en) begin
      wr_en   = 1'b1;
      wr_addr = count_q[tkres_pkg::IdxW-1:0];
      wr_data = new_rec;
    end else if (cmd_i.cmp && swap) begin
      wr_en   = 1'b1;
      wr_addr = j_q;
    end else if (cmd_i.wr_i) begin
      wr_en   = 1'b1;
      wr_addr = i_q;
    end
  end

  assign rd_en   = cmd_i.rd_i | cmd_i.rd_j | cmd_i.rd_k;
  assign rd_addr = cmd_i.rd_i ? i_q : (cmd_i.rd_j ? j_q : k_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
    if (cmd_i.cap_a || (cmd_i.cmp && swap)) begin
      a_q <= rdata_q;
    end
  end

  always_comb begin
    count_d       = count_q;
    i_d           = i_q;
    j_d           = j_q;
    k_d           = k_q;
    dev_asc_d     = dev_asc_q;
    later_first_d = later_first_q;
    if (cmd_i.clear) begin
      count_d = '0;
      i_d     = '0;
      k_d     = '0;
    end else begin
      if (store_en) begin
        count_d = count_q + tkres_pkg::CntW'(1);
      end
      if (cmd_i.wr_i) begin
        i_d = i_q + tkres_pkg::IdxW'(1);
      end
      if (out_acc) begin
        k_d = k_q + tkres_pkg::IdxW'(1);
      end
    end
    if (cmd_i.cap_a) begin
      j_d = i_q + tkres_pkg::IdxW'(1);
    end else if (cmd_i.cmp) begin
      j_d = j_q + tkres_pkg::IdxW'(1);
    end
    if (cfg_i.valid) begin
      case (cfg_i.index)
        tkres_pkg::CfgDeviceAscending: dev_asc_d     = cfg_i.data[0];
        tkres_pkg::CfgTimeLaterFirst:  later_first_d = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      i_q           <= '0;
      j_q           <= '0;
      k_q           <= '0;
      dev_asc_q     <= 1'b1;
      later_first_q <= 1'b1;
    end else begin
      count_q       <= count_d;
      i_q           <= i_d;
      j_q           <= j_d;
      k_q           <= k_d;
      dev_asc_q     <= dev_asc_d;
      later_first_q <= later_first_d;
    end
  end

  assign cfg_i.ready = 1'b1;
  assign rec_i.ready = cmd_i.in_ready;

  assign res_o.valid       = cmd_i.out_valid;
  assign res_o.out_device  = rdata_q.device;
  assign res_o.out_hours   = rdata_q.hrs;
  assign res_o.out_minutes = rdata_q.mins;
  assign res_o.out_seconds = rdata_q.secs;
  assign res_o.arrival_tag = rdata_q.tag;
  assign res_o.last_out    = k_end;

  always_comb begin
    status_o.in_acc  = load_en;
    status_o.in_last = rec_i.last_record;
    status_o.n_small = count_q <= tkres_pkg::CntW'(1);
    status_o.i_end   = (tkres_pkg::CntW'(i_q) + tkres_pkg::CntW'(2)) == count_q;
    status_o.j_end   = (tkres_pkg::CntW'(j_q) + tkres_pkg::CntW'(1)) == count_q;
    status_o.k_end   = k_end;
    status_o.out_acc = out_acc;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= tkres_pkg::CntW'(tkres_pkg::MaxRecords))
    else $error("record count exceeds the store depth");

  a_j_above_i: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cmp |-> (j_q > i_q))
    else $error("compare step with j not above i");

  a_emit_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (tkres_pkg::CntW'(k_q) < count_q))
    else $error("result emitted beyond the stored set");

  a_last_stops_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_en && rec_i.last_record) |=> !rec_i.ready)
    else $error("input still open after the last record");

endmodule

@@ rtl/tkres_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-key record exchange sort controller
// Sequences loading, the exchange sort passes and the emission of results.
// ----------------------------------------------------------------------------
module tkres_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tkres_pkg::status_t  status_i,
  output tkres_pkg::cmd_t     cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_START = 9'b000000010,
    S_RDI   = 9'b000000100,
    S_LDA   = 9'b000001000,
    S_RDJ   = 9'b000010000,
    S_CMP   = 9'b000100000,
    S_WRI   = 9'b001000000,
    S_ERD   = 9'b010000000,
    S_EOUT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_acc && status_i.in_last) begin
          state_d = S_START;
        end
      end
      S_START: begin
        state_d = status_i.n_small ? S_ERD : S_RDI;
      end
      S_RDI: begin
        cmd_o.rd_i = 1'b1;
        state_d    = S_LDA;
      end
      S_LDA: begin
        cmd_o.cap_a = 1'b1;
        state_d     = S_RDJ;
      end
      S_RDJ: begin
        cmd_o.rd_j = 1'b1;
        state_d    = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = status_i.j_end ? S_WRI : S_RDJ;
      end
      S_WRI: begin
        cmd_o.wr_i = 1'b1;
        state_d    = status_i.i_end ? S_ERD : S_RDI;
      end
      S_ERD: begin
        cmd_o.rd_k = 1'b1;
        state_d    = S_EOUT;
      end
      S_EOUT: begin
        cmd_o.out_valid = 1'b1;
        if (status_i.out_acc) begin
          if (status_i.k_end) begin
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end else begin
            state_d = S_ERD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/two_key_record_exchange_sort_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-key record exchange sort core
// Collects a set of device/time records, sorts them by device number and then
// by time stamp with an in-place exchange sort, and emits them in order.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Transfer moves
// rec_i     in   one record: device number, h:m:s time stamp, last-of-set flag
// res_o     out  one sorted record with its arrival tag and last-of-set flag
// cfg_i     in   one register write: index 0 device order, 1 time order
//
// Loading accepts a record whenever one is valid; records past the store
// depth are dropped, and the set closes on the record marked last.
// The sort then passes a start state and, for each i from 0 to n-2, reads
// record i, holds it, reads and compares each record j above i in turn,
// and writes record i back; the record store has a single read and a
// single write port, so each compare needs its own read.
// Emission reads each result from the store and then offers it for
// transfer, holding while the sink holds ready low; input is closed until
// the final result of the set transfers.
// Reset clears the record count, the controller and the order registers
// (both reset to 1); the record store itself needs no clearing pass.
//
// The controller walks i over the store; for each i it holds record i in a
// register, streams records j above i past it, and swaps in place whenever
// the held record must yield. Record i is written back at the end of the pass.
// Configuration writes are always taken and must come while the block is idle.
// ----------------------------------------------------------------------------
module two_key_record_exchange_sort_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  tkres_rec_if.sink   rec_i,
  tkres_res_if.source res_o,
  tkres_cfg_if.sink   cfg_i
);

  // Command and status groups between the sequencer and the datapath.
  tkres_pkg::cmd_t    cmd;
  tkres_pkg::status_t status;

  // The controller decides which store access or compare step happens in
  // each cycle, and when the input and output channels are open.
  tkres_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // The datapath holds the record store, the loop counters, the held record,
  // the comparator and the two order registers, and drives all channel ports.
  tkres_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rec_i    (rec_i),
    .res_o    (res_o),
    .cfg_i    (cfg_i),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule
